[rtl/sem_pkg.sv]
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the 3x3 Sobel edge magnitude unit.
// ----------------------------------------------------------------------------
package sem_pkg;

   localparam int CH_W           = 8;
   localparam int PIX_W          = 24;
   localparam int WIN_N          = 9;
   localparam int FW_W           = 11;
   localparam int FH_W           = 13;
   localparam int CSR_DATA_W     = 13;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT     = 4096;
   localparam int GRAD_W         = 12;
   localparam int NSQ_W          = 21;
   localparam int ROOT_STEP_W    = 3;
   localparam int SAT_LIMIT      = 65280;

   localparam logic [FW_W-1:0] WIDTH_RESET  = FW_W'(640);
   localparam logic [FH_W-1:0] HEIGHT_RESET = FH_W'(480);

   // register indexes
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   // item kinds
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // one window ready for the arithmetic, out-of-frame taps already zeroed
   typedef struct packed {
      logic [WIN_N-1:0][PIX_W-1:0] pix;
      logic                        last;
   } sem_item_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } sem_queue_stat_type;

   typedef enum logic {
      FRONT_IDLE,
      FRONT_UPDATE
   } sem_front_state_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_GRAD,
      BACK_SQUARE,
      BACK_ROOT,
      BACK_FINISH
   } sem_back_state_type;

endpackage

[rtl/sem_front.sv]
// ----------------------------------------------------------------------------
// sem_front
// Line stores, 3x3 window and frame position; pushes masked windows.
// ----------------------------------------------------------------------------
module sem_front #(
   parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sem_pkg::PIX_W-1:0]           req_tdata,
   input  logic                                req_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0]      csr_data,
   input  sem_pkg::sem_queue_stat_type         q_stat,
   output logic                                q_push,
   output sem_pkg::sem_item_type               q_item
);
   import sem_pkg::*;

   localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
   localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RC_W   = FH_W + 2;

   logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

   logic [FW_W-1:0]     width_ff;
   logic [FH_W-1:0]     height_ff;
   logic [CNT_W-1:0]    col_ff, col_in, col_s_ff, col_a;
   logic [FH_W-1:0]     row_ff, row_in;
   logic [PIX_W-1:0]    pix_ff, top_ff, mid_ff;
   logic [PIX_W-1:0]    win_ff [WIN_N];
   logic [PIX_W-1:0]    win_in [WIN_N];
   sem_front_state_type state_ff, state_in;

   logic [CNT_W-1:0]    eff_w, cc, col_nx;
   logic [FH_W-1:0]     eff_h;
   logic signed [RC_W-1:0] rc, h_s;
   logic                accept, res_valid, res_last;
   logic                top_ok, bot_ok, left_ok, right_ok;
   logic [WIN_N-1:0]    ok;

   assign csr_ready = 1'b1;
   assign accept    = req_tvalid && req_tready;
   assign req_tready = (state_ff == FRONT_IDLE) && !q_stat.full;

   // effective frame size
   always_comb begin
      if (width_ff == '0)                  eff_w = CNT_W'(1);
      else if (int'(width_ff) > MAX_WIDTH) eff_w = CNT_W'(MAX_WIDTH);
      else                                 eff_w = CNT_W'(width_ff);
      if (height_ff == '0)                  eff_h = FH_W'(1);
      else if (int'(height_ff) > MAX_HEIGHT) eff_h = FH_W'(MAX_HEIGHT);
      else                                  eff_h = height_ff;
   end

   assign col_a = (col_ff >= eff_w) ? '0 : col_ff;

   // line store read on accept, write back in the update cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         top_ff   <= upper_mem[col_a[ADDR_W-1:0]];
         mid_ff   <= middle_mem[col_a[ADDR_W-1:0]];
         col_s_ff <= col_a;
         pix_ff   <= (req_tuser == CMD_FLUSH) ? '0 : req_tdata;
      end
      if (state_ff == FRONT_UPDATE) begin
         upper_mem[col_s_ff[ADDR_W-1:0]]  <= mid_ff;
         middle_mem[col_s_ff[ADDR_W-1:0]] <= pix_ff;
      end
   end

   // window shift
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r*3]     = win_ff[r*3+1];
         win_in[r*3 + 1] = win_ff[r*3+2];
      end
      win_in[2] = top_ff;
      win_in[5] = mid_ff;
      win_in[8] = pix_ff;
   end

   // position of the output pixel and next position
   always_comb begin
      h_s = $signed({2'b00, eff_h});
      if (col_s_ff == '0) begin
         cc = eff_w - CNT_W'(1);
         rc = $signed({2'b00, row_ff}) - RC_W'(2);
      end else begin
         cc = col_s_ff - CNT_W'(1);
         rc = $signed({2'b00, row_ff}) - RC_W'(1);
      end
      res_valid = (rc >= 0) && (rc < h_s);
      res_last  = (rc == h_s - RC_W'(1)) && (cc == eff_w - CNT_W'(1));
      col_nx    = col_s_ff + CNT_W'(1);
      col_in    = col_nx;
      row_in    = row_ff;
      if (col_nx >= eff_w) begin
         col_in = '0;
         row_in = row_ff + FH_W'(1);
      end
      if (res_valid && res_last) begin
         col_in = '0;
         row_in = '0;
      end
      top_ok   = (rc != '0);
      bot_ok   = (rc != h_s - RC_W'(1));
      left_ok  = (cc != '0);
      right_ok = (cc != eff_w - CNT_W'(1));
      for (int k = 0; k < WIN_N; k++) begin
         ok[k] = 1'b1;
         if (k < 3 && !top_ok)     ok[k] = 1'b0;
         if (k >= 6 && !bot_ok)    ok[k] = 1'b0;
         if (k % 3 == 0 && !left_ok)  ok[k] = 1'b0;
         if (k % 3 == 2 && !right_ok) ok[k] = 1'b0;
      end
      for (int k = 0; k < WIN_N; k++) begin
         q_item.pix[k] = ok[k] ? win_in[k] : '0;
      end
      q_item.last = res_last;
      q_push      = (state_ff == FRONT_UPDATE) && res_valid;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FRONT_IDLE:   if (accept) state_in = FRONT_UPDATE;
         FRONT_UPDATE: state_in = FRONT_IDLE;
         default:      state_in = FRONT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FRONT_IDLE;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         for (int k = 0; k < WIN_N; k++) win_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == FRONT_UPDATE) begin
            col_ff <= col_in;
            row_ff <= row_in;
            for (int k = 0; k < WIN_N; k++) win_ff[k] <= win_in[k];
         end
         // a register write restarts the frame
         if (csr_valid && csr_ready) begin
            col_ff <= '0;
            row_ff <= '0;
            unique case (csr_index)
               CSR_FRAME_WIDTH:  width_ff  <= csr_data[FW_W-1:0];
               CSR_FRAME_HEIGHT: height_ff <= csr_data[FH_W-1:0];
               default:          ;
            endcase
         end
      end
   end

endmodule

[rtl/sem_queue.sv]
// ----------------------------------------------------------------------------
// sem_queue
// Two-entry queue of windows between front and back.
// ----------------------------------------------------------------------------
module sem_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  sem_pkg::sem_item_type        push_item,
   input  logic                         pop,
   output sem_pkg::sem_item_type        pop_item,
   output sem_pkg::sem_queue_stat_type  stat
);
   import sem_pkg::*;

   sem_item_type entry_ff [2];
   logic         wr_ff, rd_ff;
   logic [1:0]   count_ff;

   assign stat.full  = (count_ff == 2'd2);
   assign stat.empty = (count_ff == 2'd0);
   assign pop_item   = entry_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

[rtl/sem_back.sv]
// ----------------------------------------------------------------------------
// sem_back
// Sobel gradients, squared magnitude and rounded root per channel.
// ----------------------------------------------------------------------------
module sem_back (
   input  logic                          clock,
   input  logic                          reset,
   input  sem_pkg::sem_queue_stat_type   q_stat,
   input  sem_pkg::sem_item_type         q_item,
   output logic                          q_pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [sem_pkg::PIX_W-1:0]     rsp_tdata,
   output logic                          rsp_tlast
);
   import sem_pkg::*;

   sem_back_state_type       state_ff, state_in;
   sem_item_type             item_ff;
   logic signed [GRAD_W-1:0] gx_ff [3];
   logic signed [GRAD_W-1:0] gy_ff [3];
   logic signed [GRAD_W-1:0] gx_in [3];
   logic signed [GRAD_W-1:0] gy_in [3];
   logic [NSQ_W-1:0]         n_ff [3];
   logic [NSQ_W-1:0]         n_in [3];
   logic [CH_W-1:0]          root_ff [3];
   logic [CH_W-1:0]          root_in [3];
   logic [CH_W-1:0]          mag [3];
   logic [ROOT_STEP_W-1:0]   step_ff;
   logic                     valid_ff, last_ff;
   logic [PIX_W-1:0]         data_ff;
   logic                     load;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   // per-channel arithmetic, channel 0 is red in the top byte
   always_comb begin
      logic signed [GRAD_W-1:0] a [WIN_N];
      logic [CH_W-1:0]          t;
      logic [2*CH_W-1:0]        tt, ss;
      logic [2*GRAD_W-1:0]      sx, sy;
      for (int ch = 0; ch < 3; ch++) begin
         for (int k = 0; k < WIN_N; k++) begin
            a[k] = $signed({4'b0000, item_ff.pix[k][(2-ch)*CH_W +: CH_W]});
         end
         gx_in[ch] = (a[2] + (a[5] <<< 1) + a[8]) - (a[0] + (a[3] <<< 1) + a[6]);
         gy_in[ch] = (a[6] + (a[7] <<< 1) + a[8]) - (a[0] + (a[1] <<< 1) + a[2]);
         sx = (2*GRAD_W)'(gx_ff[ch] * gx_ff[ch]);
         sy = (2*GRAD_W)'(gy_ff[ch] * gy_ff[ch]);
         n_in[ch] = NSQ_W'(sx + sy);
         // one bit of the root per cycle
         t  = root_ff[ch] | (CH_W'(1) << step_ff);
         tt = t * t;
         root_in[ch] = (NSQ_W'(tt) <= n_ff[ch]) ? t : root_ff[ch];
         // round to nearest, saturate
         ss = root_ff[ch] * root_ff[ch];
         if (n_ff[ch] > NSQ_W'(SAT_LIMIT))
            mag[ch] = '1;
         else if (n_ff[ch] > NSQ_W'(ss) + NSQ_W'(root_ff[ch]))
            mag[ch] = root_ff[ch] + CH_W'(1);
         else
            mag[ch] = root_ff[ch];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      load     = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!q_stat.empty) begin
               q_pop    = 1'b1;
               state_in = BACK_GRAD;
            end
         end
         BACK_GRAD:   state_in = BACK_SQUARE;
         BACK_SQUARE: state_in = BACK_ROOT;
         BACK_ROOT:   if (step_ff == '0) state_in = BACK_FINISH;
         BACK_FINISH: begin
            if (!valid_ff || rsp_tready) begin
               load     = 1'b1;
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) item_ff <= q_item;
      unique case (state_ff)
         BACK_GRAD: begin
            for (int ch = 0; ch < 3; ch++) begin
               gx_ff[ch] <= gx_in[ch];
               gy_ff[ch] <= gy_in[ch];
            end
         end
         BACK_SQUARE: begin
            for (int ch = 0; ch < 3; ch++) begin
               n_ff[ch]    <= n_in[ch];
               root_ff[ch] <= '0;
            end
            step_ff <= '1;
         end
         BACK_ROOT: begin
            for (int ch = 0; ch < 3; ch++) root_ff[ch] <= root_in[ch];
            step_ff <= step_ff - ROOT_STEP_W'(1);
         end
         default: ;
      endcase
      if (load) begin
         data_ff <= {mag[0], mag[1], mag[2]};
         last_ff <= item_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load)            valid_ff <= 1'b1;
         else if (rsp_tready) valid_ff <= 1'b0;
      end
   end

endmodule

[rtl/sobel_edge_magnitude_3x3_unit.sv]
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_3x3_unit
// 3x3 Sobel gradient magnitude over an RGB raster stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_*: one pixel (or flush tick, tuser = 1) per transfer, raster order.
//   rsp_*: magnitude per channel; tlast marks the frame's final pixel.
//   csr_*: frame_width (index 0) and frame_height (index 1); a write restarts
//     the frame. Always ready. Write only while the unit is idle.
//   The result for pixel p is produced by transfer p + width + 1; after the
//   frame, width + 1 flush ticks drain the remaining results.
// Flow:
//   The front takes an item while idle (line store read), then spends an
//   update state writing back before it is ready again; it also waits while
//   the queue is full. The back handles one window at a time (gradient,
//   square, 8 root steps, rounding) and pops the next only after loading the
//   result. A two-entry queue lets the front run ahead of the back.
// Reset: counters, window and queue clear; width 640, height 480. The line
//   stores are not cleared; their top-row contents are masked.
// Stall: rsp_tvalid holds with data until rsp_tready; the queue fills and
//   then req_tready drops.
module sobel_edge_magnitude_3x3_unit #(
   parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sem_pkg::PIX_W-1:0]       req_tdata,   // in_red, in_green, in_blue
   input  logic                            req_tuser,   // cmd
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sem_pkg::PIX_W-1:0]       rsp_tdata,   // out_red, out_green, out_blue
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0]  csr_data
);
   import sem_pkg::*;

   sem_queue_stat_type q_stat;
   sem_item_type       push_item, pop_item;
   logic               push, pop;
   logic [PIX_W-1:0]   in_pix, out_pix;

   // ports carry red in the low byte, internal words carry it high
   assign in_pix    = {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};
   assign rsp_tdata = {out_pix[7:0], out_pix[15:8], out_pix[23:16]};

   sem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata(in_pix), .req_tuser,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .q_stat, .q_push(push), .q_item(push_item)
   );

   sem_queue u_queue (
      .clock, .reset,
      .push, .push_item, .pop, .pop_item, .stat(q_stat)
   );

   sem_back u_back (
      .clock, .reset,
      .q_stat, .q_item(pop_item), .q_pop(pop),
      .rsp_tvalid, .rsp_tready, .rsp_tdata(out_pix), .rsp_tlast
   );

endmodule

[rtl/sem_checker.sv]
// ----------------------------------------------------------------------------
// sem_port_checks
// Port-level checks of the Sobel unit, bound to the top level.
// ----------------------------------------------------------------------------
module sem_port_checks (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [sem_pkg::PIX_W-1:0]  rsp_tdata,
   input logic                       rsp_tlast
);
   import sem_pkg::*;

   // nothing is presented right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // the front is busy for the cycle after each transfer
   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken back to back");

   // early result after a transfer: cannot fail, antecedent has !rsp_tvalid
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && $past(!rsp_tvalid) && $past(!rsp_tvalid, 2) &&
      $past(req_tvalid && req_tready) |-> !rsp_tvalid)
      else $error("result too early");

endmodule

bind sobel_edge_magnitude_3x3_unit sem_port_checks u_sem_port_checks (
   .clock, .reset, .req_tvalid, .req_tready,
   .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
);
